### src/lccd_pkg.sv
// lccd_pkg: shared types and constants for the linear ccd readout sequencer
// used by lccd_frame_store and linear_ccd_readout_sequencer_unit; no dependencies
package lccd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRE1    = 3'd1,
    PH_PRE2    = 3'd2,
    PH_PRE3    = 3'd3,
    PH_EXPOSE  = 3'd4,
    PH_CONVERT = 3'd5,
    PH_HOLD    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_EXPOSURE = 2'd0,
    REG_SETUP    = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_index_t;

  localparam logic [15:0] EXPOSURE_RESET = 16'd30;
  localparam logic [7:0]  SETUP_RESET    = 8'd8;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20000;

  // top 8 of the 12 conversion bits are kept
  localparam int unsigned ADC_SHIFT = 4;

  // control from the sequencer to the frame store for one accepted request
  typedef struct packed {
    logic load;     // a request is accepted this cycle
    logic wr_en;    // store a converted pixel
    logic wr_bank;
    logic rd_en;    // read request
    logic rd_bank;
    logic commit;   // write bank becomes the committed bank
  } store_ctl_t;

endpackage

### src/lccd_frame_store.sv
// lccd_frame_store: two-bank pixel memory with registered read port
// depends on lccd_pkg for the control struct
module lccd_frame_store #(
  parameter int unsigned PIXEL_COUNT = 128,
  parameter int unsigned PW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lccd_pkg::store_ctl_t ctl,
  input  logic [PW-1:0]      wr_pos,
  input  logic [7:0]         wr_data,
  input  logic [6:0]         rd_index,
  output logic [7:0]         rd_value
);
  import lccd_pkg::*;

  localparam int unsigned DEPTH = 2 * PIXEL_COUNT;
  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_ok_r;
  // a bank reads as zero until a full frame has been committed into it
  logic [1:0]    filled_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [11:0]   rd_sum;
  logic          idx_ok;

  assign wr_addr = ctl.wr_bank ? AW'(12'(PIXEL_COUNT) + 12'(wr_pos)) : AW'(wr_pos);
  assign rd_sum  = (ctl.rd_bank ? 12'(PIXEL_COUNT) : 12'd0) + 12'(rd_index);
  assign rd_addr = AW'(rd_sum);
  assign idx_ok  = 12'(rd_index) < 12'(PIXEL_COUNT);

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.load && ctl.rd_en && idx_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r  <= 1'b0;
      filled_r <= 2'b00;
    end else if (ctl.load) begin
      rd_ok_r <= ctl.rd_en && idx_ok && filled_r[ctl.rd_bank];
      if (ctl.commit) begin
        filled_r[ctl.wr_bank] <= 1'b1;
      end
    end
  end

  assign rd_value = rd_ok_r ? rd_data_r : 8'd0;

endmodule

### src/linear_ccd_readout_sequencer_unit.sv
// linear_ccd_readout_sequencer_unit: top level, tick sequencer, apb registers, handshake
// depends on lccd_pkg and lccd_frame_store
//
// Each request is a tick, a frame start, a pixel read or a no-op. One request
// is accepted per clock cycle unless stalled; its result appears in the output register
// on the next cycle; the only extra latency source is the registered read port of the
// pixel memory, which lines up with that result register. A full stall on the output
// holds the result and stalls the input. Reads return the last committed frame; a bank
// that never got a full frame reads as zero, so no clearing pass is needed after reset.
module linear_ccd_readout_sequencer_unit #(
  parameter int unsigned PIXEL_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic        in_adc_done,
  input  logic [11:0] in_adc_value,
  input  logic [6:0]  in_pixel_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_si_level,
  output logic        out_clk_level,
  output logic        out_adc_start,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic        out_frame_error,
  output logic [7:0]  out_read_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lccd_pkg::*;

  localparam int unsigned PW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(PIXEL_COUNT - 1);

  // configuration registers
  logic [15:0] exposure_r;
  logic [7:0]  setup_r;
  logic [15:0] timeout_r;
  reg_index_t  reg_sel;

  // sequencer state
  phase_t        phase_r, phase_nxt;
  logic [15:0]   delay_r, delay_nxt;
  logic [16:0]   wait_r, wait_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          bank_r, bank_nxt;

  // result register
  logic out_valid_r;
  logic si_r, ck_r, start_r, busy_r, fdone_r, ferr_r;
  logic si_nxt, ck_nxt, start_nxt, fdone_nxt, ferr_nxt;

  logic        accept;
  logic        delay_end;
  logic [16:0] wait_inc;
  action_t     action;
  store_ctl_t  ctl;
  logic [7:0]  rd_value;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r <= EXPOSURE_RESET;
      setup_r    <= SETUP_RESET;
      timeout_r  <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_EXPOSURE: exposure_r <= pwdata[15:0];
        REG_SETUP:    setup_r    <= pwdata[7:0];
        REG_TIMEOUT:  timeout_r  <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXPOSURE: prdata = {16'd0, exposure_r};
      REG_SETUP:    prdata = {24'd0, setup_r};
      REG_TIMEOUT:  prdata = {16'd0, timeout_r};
      default:      prdata = 32'd0;
    endcase
  end

  // one-deep output register, refilled in the cycle it drains
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign action   = action_t'(in_action);

  assign delay_end = delay_r <= 16'd1;
  assign wait_inc  = wait_r + 17'd1;

  always_comb begin
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    wait_nxt  = wait_r;
    pos_nxt   = pos_r;
    bank_nxt  = bank_r;
    start_nxt = 1'b0;
    fdone_nxt = 1'b0;
    ferr_nxt  = 1'b0;
    ctl       = '0;
    ctl.load    = accept;
    ctl.wr_bank = ~bank_r;
    ctl.rd_bank = bank_r;
    case (action)
      ACT_START: begin
        if (phase_r == PH_IDLE) begin
          pos_nxt   = '0;
          wait_nxt  = '0;
          phase_nxt = PH_PRE1;
          delay_nxt = 16'(setup_r);
        end
      end
      ACT_READ: begin
        ctl.rd_en = 1'b1;
      end
      ACT_TICK: begin
        unique case (phase_r)
          PH_PRE1, PH_PRE2: begin
            if (delay_end) begin
              phase_nxt = (phase_r == PH_PRE1) ? PH_PRE2 : PH_PRE3;
              delay_nxt = 16'(setup_r);
            end else begin
              delay_nxt = delay_r - 16'd1;
            end
          end
          PH_PRE3: begin
            if (delay_end) begin
              phase_nxt = PH_EXPOSE;
              delay_nxt = exposure_r;
            end else begin
              delay_nxt = delay_r - 16'd1;
            end
          end
          PH_EXPOSE: begin
            if (delay_r == 16'd0) begin
              start_nxt = 1'b1;
              wait_nxt  = '0;
              phase_nxt = PH_CONVERT;
            end else begin
              delay_nxt = delay_r - 16'd1;
            end
          end
          PH_CONVERT: begin
            if (in_adc_done) begin
              ctl.wr_en = 1'b1;
              phase_nxt = PH_HOLD;
              delay_nxt = 16'(setup_r);
            end else begin
              wait_nxt = wait_inc;
              // abort once the wait passes the timeout; old frame stays committed
              if (wait_inc >= 17'(timeout_r) + 17'd1) begin
                ferr_nxt  = 1'b1;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_HOLD: begin
            if (delay_end) begin
              pos_nxt = pos_r + PW'(1);
              if (pos_r == LAST_POS) begin
                bank_nxt   = ~bank_r;
                ctl.commit = 1'b1;
                fdone_nxt  = 1'b1;
                phase_nxt  = PH_IDLE;
              end else begin
                phase_nxt = PH_EXPOSE;
                delay_nxt = exposure_r;
              end
            end else begin
              delay_nxt = delay_r - 16'd1;
            end
          end
          PH_IDLE: ;
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (phase_nxt)
      PH_PRE2: begin
        si_nxt = 1'b1;
        ck_nxt = 1'b0;
      end
      PH_EXPOSE, PH_CONVERT: begin
        si_nxt = 1'b0;
        ck_nxt = 1'b0;
      end
      default: begin
        si_nxt = 1'b0;
        ck_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= '0;
      wait_r      <= '0;
      pos_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        delay_r <= delay_nxt;
        wait_r  <= wait_nxt;
        pos_r   <= pos_nxt;
        bank_r  <= bank_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      si_r    <= si_nxt;
      ck_r    <= ck_nxt;
      start_r <= start_nxt;
      busy_r  <= phase_nxt != PH_IDLE;
      fdone_r <= fdone_nxt;
      ferr_r  <= ferr_nxt;
    end
  end

  lccd_frame_store #(
    .PIXEL_COUNT(PIXEL_COUNT),
    .PW(PW)
  ) u_store (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .wr_pos(pos_r),
    .wr_data(in_adc_value[11:ADC_SHIFT]),
    .rd_index(in_pixel_index),
    .rd_value(rd_value)
  );

  assign out_valid       = out_valid_r;
  assign out_si_level    = si_r;
  assign out_clk_level   = ck_r;
  assign out_adc_start   = start_r;
  assign out_busy_res    = busy_r;
  assign out_frame_done  = fdone_r;
  assign out_frame_error = ferr_r;
  assign out_read_value  = rd_value;

endmodule

### tb/linear_ccd_readout_sequencer_unit_test.sv
// self-checking bench for linear_ccd_readout_sequencer_unit: a scan tracker predicts the
// sensor line levels, pulses and pixel reads for each request and checks every result
// depends on lccd_pkg and the rtl under src
module linear_ccd_readout_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lccd_pkg::*;

  localparam int unsigned PIXELS = 128;
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic       si_level;
    logic       clk_level;
    logic       adc_start;
    logic       busy_res;
    logic       frame_done;
    logic       frame_error;
    logic [7:0] read_value;
  } sensor_levels_t;

  class scan_tracker;
    logic [15:0]    exposure;
    logic [7:0]     setup;
    logic [15:0]    timeout;
    phase_t         ph;
    logic [15:0]    delay_cnt;
    logic [16:0]    wait_cnt;
    int unsigned    pix_pos;
    logic           bank;
    logic [7:0]     pixels [256];
    sensor_levels_t pending_levels [$];
    int             mismatches;

    function new();
      exposure   = EXPOSURE_RESET;
      setup      = SETUP_RESET;
      timeout    = TIMEOUT_RESET;
      ph         = PH_IDLE;
      delay_cnt  = '0;
      wait_cnt   = '0;
      pix_pos    = 0;
      bank       = 1'b0;
      mismatches = 0;
      foreach (pixels[i]) pixels[i] = '0;
    endfunction

    function void enter_phase(phase_t p);
      ph = p;
      delay_cnt = (p == PH_EXPOSE) ? exposure : {8'd0, setup};
    endfunction

    // a zero setup count behaves like one
    function bit setup_elapsed();
      if (delay_cnt <= 16'd1) return 1'b1;
      delay_cnt--;
      return 1'b0;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void set_register(reg_index_t r, logic [31:0] word);
      case (r)
        REG_EXPOSURE: exposure = word[15:0];
        REG_SETUP:    setup    = word[7:0];
        REG_TIMEOUT:  timeout  = word[15:0];
        default: ;
      endcase
    endfunction

    function void check_register(reg_index_t r, logic [31:0] got);
      logic [31:0] want;
      case (r)
        REG_EXPOSURE: want = {16'd0, exposure};
        REG_SETUP:    want = {24'd0, setup};
        REG_TIMEOUT:  want = {16'd0, timeout};
        default:      want = '0;
      endcase
      if (got !== want)
        note_mismatch($sformatf("register %s read expected %0h got %0h", r.name(), want, got));
    endfunction

    function void note_request(action_t act, logic done, logic [11:0] val, logic [6:0] idx);
      sensor_levels_t r;
      r = '0;
      case (act)
        ACT_START: begin
          if (ph == PH_IDLE) begin
            pix_pos  = 0;
            wait_cnt = '0;
            enter_phase(PH_PRE1);
          end
        end
        ACT_READ: r.read_value = pixels[{bank, idx}];
        ACT_TICK: begin
          case (ph)
            PH_PRE1: if (setup_elapsed()) enter_phase(PH_PRE2);
            PH_PRE2: if (setup_elapsed()) enter_phase(PH_PRE3);
            PH_PRE3: if (setup_elapsed()) enter_phase(PH_EXPOSE);
            PH_EXPOSE: begin
              if (delay_cnt == 16'd0) begin
                r.adc_start = 1'b1;
                wait_cnt = '0;
                ph = PH_CONVERT;
              end else begin
                delay_cnt--;
              end
            end
            PH_CONVERT: begin
              if (done) begin
                pixels[{~bank, pix_pos[6:0]}] = 8'(val >> ADC_SHIFT);
                enter_phase(PH_HOLD);
              end else begin
                wait_cnt = wait_cnt + 17'd1;
                if (int'(wait_cnt) >= int'(timeout) + 1) begin
                  r.frame_error = 1'b1;
                  ph = PH_IDLE;
                end
              end
            end
            PH_HOLD: begin
              if (setup_elapsed()) begin
                pix_pos++;
                if (pix_pos >= PIXELS) begin
                  bank = ~bank;
                  r.frame_done = 1'b1;
                  ph = PH_IDLE;
                end else begin
                  enter_phase(PH_EXPOSE);
                end
              end
            end
            default: ph = PH_IDLE;
          endcase
        end
        default: ;
      endcase
      r.si_level  = (ph == PH_PRE2);
      r.clk_level = !(ph == PH_PRE2 || ph == PH_EXPOSE || ph == PH_CONVERT);
      r.busy_res  = (ph != PH_IDLE);
      pending_levels.push_back(r);
    endfunction

    function void check_result(sensor_levels_t got);
      sensor_levels_t want;
      string bad;
      if (pending_levels.size() == 0) begin
        note_mismatch("result arrived with nothing expected");
        return;
      end
      want = pending_levels.pop_front();
      bad = "";
      if (got.si_level !== want.si_level)       bad = {bad, " si_level"};
      if (got.clk_level !== want.clk_level)     bad = {bad, " clk_level"};
      if (got.adc_start !== want.adc_start)     bad = {bad, " adc_start"};
      if (got.busy_res !== want.busy_res)       bad = {bad, " busy_res"};
      if (got.frame_done !== want.frame_done)   bad = {bad, " frame_done"};
      if (got.frame_error !== want.frame_error) bad = {bad, " frame_error"};
      if (got.read_value !== want.read_value)   bad = {bad, " read_value"};
      if (bad != "")
        note_mismatch({
          $sformatf("%s: expected si=%0b clk=%0b start=%0b busy=%0b done=%0b err=%0b rd=%0d",
                    bad, want.si_level, want.clk_level, want.adc_start, want.busy_res,
                    want.frame_done, want.frame_error, want.read_value),
          $sformatf(", got si=%0b clk=%0b start=%0b busy=%0b done=%0b err=%0b rd=%0d",
                    got.si_level, got.clk_level, got.adc_start, got.busy_res,
                    got.frame_done, got.frame_error, got.read_value)});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_TICK;
  logic        in_adc_done = 1'b0;
  logic [11:0] in_adc_value = '0;
  logic [6:0]  in_pixel_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_si_level;
  logic        out_clk_level;
  logic        out_adc_start;
  logic        out_busy_res;
  logic        out_frame_done;
  logic        out_frame_error;
  logic [7:0]  out_read_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scan_tracker sb = new();
  int          sent_items = 0;
  int          burst_left = 0;
  int unsigned rcv_cycle = 0;

  always #5 clk = ~clk;

  linear_ccd_readout_sequencer_unit #(.PIXEL_COUNT(PIXELS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_adc_done(in_adc_done), .in_adc_value(in_adc_value), .in_pixel_index(in_pixel_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_si_level(out_si_level),
    .out_clk_level(out_clk_level), .out_adc_start(out_adc_start),
    .out_busy_res(out_busy_res), .out_frame_done(out_frame_done),
    .out_frame_error(out_frame_error), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: check accepted results, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_si_level, out_clk_level, out_adc_start, out_busy_res,
                       out_frame_done, out_frame_error, out_read_value});
    rcv_cycle <= rcv_cycle + 1;
    case (rcv_cycle[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ((rcv_cycle % 7) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        stuck = 0;
      else
        stuck++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic send_request(input action_t act, input logic done, input logic [11:0] val,
                              input logic [6:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_adc_done    <= done;
    in_adc_value   <= val;
    in_pixel_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, done, val, idx);
    if (act != ACT_NONE) sent_items++;
  endtask

  // hold the sender until every result is back
  task automatic settle_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t r, input logic [15:0] v);
    logic [31:0] mask;
    logic [31:0] word;
    mask = (r == REG_SETUP) ? 32'h0000_00ff : 32'h0000_ffff;
    word = ($urandom & ~mask) | ({16'd0, v} & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(r, word);
    // read it straight back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_register(r, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_idle_traffic(input int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: send_request(ACT_TICK, 1'($urandom), pick_sample(), 7'($urandom));
        1: send_request(ACT_NONE, 1'($urandom), pick_sample(), 7'($urandom));
        default: send_request(ACT_READ, 1'($urandom), pick_sample(), 7'($urandom));
      endcase
    end
  endtask

  // one scan with random content; the converter never answers at pixel abort_pix
  task automatic run_frame(input int abort_pix);
    bit in_conv;
    int polls;
    int target;
    logic give;
    in_conv = 1'b0;
    polls = 0;
    target = 0;
    send_request(ACT_START, 1'($urandom), pick_sample(), 7'($urandom));
    while (sb.ph != PH_IDLE) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_request(ACT_READ, 1'($urandom), pick_sample(), 7'($urandom));
          1: send_request(ACT_NONE, 1'($urandom), pick_sample(), 7'($urandom));
          default: send_request(ACT_START, 1'($urandom), pick_sample(), 7'($urandom));
        endcase
      end else if (sb.ph == PH_CONVERT) begin
        if (!in_conv) begin
          in_conv = 1'b1;
          polls = 0;
          target = $urandom_range(0, (sb.timeout < 16'd3) ? int'(sb.timeout) : 3);
        end
        give = (polls >= target) && (int'(sb.pix_pos) != abort_pix);
        send_request(ACT_TICK, give, pick_sample(), 7'($urandom));
        polls++;
      end else begin
        in_conv = 1'b0;
        send_request(ACT_TICK, 1'($urandom), pick_sample(), 7'($urandom));
      end
    end
  endtask

  initial begin
    int first_random;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents and requests that change nothing
    send_request(ACT_READ, 1'b1, 12'hfff, 7'd0);
    send_request(ACT_READ, 1'b0, 12'h000, 7'd127);
    send_request(ACT_NONE, 1'b1, 12'hfff, 7'h7f);
    send_request(ACT_TICK, 1'b1, 12'hfff, 7'd0);

    // shortest timing, zero setup, converter timeout at the second pixel
    settle_results();
    write_register(REG_EXPOSURE, 16'd0);
    write_register(REG_SETUP, 16'd0);
    write_register(REG_TIMEOUT, 16'd0);
    send_request(ACT_START, 1'b0, 12'h000, 7'd0);
    send_request(ACT_START, 1'b1, 12'hfff, 7'd0);
    send_request(ACT_READ, 1'b0, 12'h000, 7'd5);
    send_request(ACT_NONE, 1'b1, 12'hfff, 7'd0);
    repeat (3) send_request(ACT_TICK, 1'b0, 12'h000, 7'd0);
    send_request(ACT_TICK, 1'b1, 12'h123, 7'd0);
    send_request(ACT_TICK, 1'b1, 12'hfff, 7'd0);
    send_request(ACT_TICK, 1'b0, 12'h000, 7'd0);
    send_request(ACT_TICK, 1'b1, 12'h000, 7'd0);
    send_request(ACT_TICK, 1'b0, 12'h000, 7'd0);
    send_request(ACT_READ, 1'b0, 12'h000, 7'd0);

    // widest register values, then a longer scan aborted on the first conversion
    settle_results();
    write_register(REG_EXPOSURE, 16'hffff);
    write_register(REG_SETUP, 16'h00ff);
    write_register(REG_TIMEOUT, 16'hffff);
    write_register(REG_EXPOSURE, 16'd40);
    write_register(REG_SETUP, 16'd24);
    write_register(REG_TIMEOUT, 16'd0);
    run_frame(0);

    // longest timeout, full frame then readback of the committed bank
    settle_results();
    write_register(REG_EXPOSURE, 16'd0);
    write_register(REG_SETUP, 16'd1);
    write_register(REG_TIMEOUT, 16'hffff);
    run_frame(-1);
    repeat (16) send_request(ACT_READ, 1'($urandom), pick_sample(), 7'($urandom));

    first_random = sent_items;
    while (sent_items - first_random < RANDOM_ITEMS) begin
      settle_results();
      write_register(REG_EXPOSURE, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(3, 6))
                                                               : 16'($urandom_range(0, 2)));
      write_register(REG_SETUP, 16'($urandom_range(0, 3)));
      write_register(REG_TIMEOUT, 16'($urandom_range(0, 4)));
      run_frame(($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : -1);
      send_idle_traffic($urandom_range(4, 12));
    end

    settle_results();
    repeat (5) @(posedge clk);
    if (sb.pending_levels.size() != 0)
      sb.note_mismatch($sformatf("%0d results never arrived", sb.pending_levels.size()));
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
